// File: rtl/core/ffba_pkg.sv
// Shared types, constants and microcode ROM of the first-fit block allocator.
package ffba_pkg;

    // Arena and table geometry
    localparam int ARENA_BYTES  = 2048;
    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 12;

    // Field widths
    localparam int SIZE_W = 12;
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = IDX_W + 1;
    localparam int OFF_W  = $clog2(ARENA_BYTES);
    localparam int TOP_W  = $clog2(ARENA_BYTES + 1);
    localparam int SUM_W  = $clog2(ARENA_BYTES + HEADER_BYTES + (1 << SIZE_W));
    localparam int STAT_W = 2;

    // Port packing
    localparam int S_DATA_W = ((SIZE_W + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((OFF_W + IDX_W + SIZE_W + 7) / 8) * 8;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_ZERO      = 2'd1,
        ST_NOSPACE   = 2'd2,
        ST_BADHANDLE = 2'd3
    } status_t;

    typedef enum logic {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } func_t;

    // One table entry
    typedef struct packed {
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  start;
        logic              free;
    } entry_t;

    // Microprogram step addresses
    typedef enum logic [3:0] {
        U_IDLE,
        U_DISPATCH,
        U_SCAN,
        U_APPEND_CHK,
        U_FREE_CHK,
        U_ZERO,
        U_CLAIM,
        U_NOSPACE,
        U_APPEND,
        U_BADH,
        U_FREE,
        U_RESP
    } step_t;

    // Jump conditions
    typedef enum logic [3:0] {
        C_NEVER,
        C_IN_XFER,
        C_FUNC_FREE,
        C_REQ_ZERO,
        C_HIT,
        C_SCAN_END,
        C_FULL,
        C_BAD_HANDLE,
        C_OUT_FREE
    } cond_t;

    // Datapath operations
    typedef enum logic [2:0] {
        A_NONE,
        A_ACCEPT,
        A_SCAN,
        A_CLAIM,
        A_APPEND,
        A_FREE,
        A_ERR,
        A_RESP
    } act_t;

    // Control word: two prioritized conditional jumps, a default target, an operation
    typedef struct packed {
        cond_t   cond_a;
        step_t   tgt_a;
        cond_t   cond_b;
        step_t   tgt_b;
        step_t   tgt_else;
        act_t    act;
        status_t st;
    } cw_t;

    // Microcode ROM
    function automatic cw_t ucode(step_t s);
        cw_t w;
        w = '{C_NEVER, U_IDLE, C_NEVER, U_IDLE, U_IDLE, A_NONE, ST_OK};
        unique case (s)
            U_IDLE:       w = '{C_IN_XFER, U_DISPATCH, C_NEVER, U_IDLE, U_IDLE,
                                A_ACCEPT, ST_OK};
            U_DISPATCH:   w = '{C_FUNC_FREE, U_FREE_CHK, C_REQ_ZERO, U_ZERO, U_SCAN,
                                A_NONE, ST_OK};
            U_SCAN:       w = '{C_HIT, U_CLAIM, C_SCAN_END, U_APPEND_CHK, U_SCAN,
                                A_SCAN, ST_OK};
            U_APPEND_CHK: w = '{C_FULL, U_NOSPACE, C_NEVER, U_IDLE, U_APPEND,
                                A_NONE, ST_OK};
            U_FREE_CHK:   w = '{C_BAD_HANDLE, U_BADH, C_NEVER, U_IDLE, U_FREE,
                                A_NONE, ST_OK};
            U_ZERO:       w = '{C_NEVER, U_IDLE, C_NEVER, U_IDLE, U_RESP,
                                A_ERR, ST_ZERO};
            U_CLAIM:      w = '{C_NEVER, U_IDLE, C_NEVER, U_IDLE, U_RESP,
                                A_CLAIM, ST_OK};
            U_NOSPACE:    w = '{C_NEVER, U_IDLE, C_NEVER, U_IDLE, U_RESP,
                                A_ERR, ST_NOSPACE};
            U_APPEND:     w = '{C_NEVER, U_IDLE, C_NEVER, U_IDLE, U_RESP,
                                A_APPEND, ST_OK};
            U_BADH:       w = '{C_NEVER, U_IDLE, C_NEVER, U_IDLE, U_RESP,
                                A_ERR, ST_BADHANDLE};
            U_FREE:       w = '{C_NEVER, U_IDLE, C_NEVER, U_IDLE, U_RESP,
                                A_FREE, ST_OK};
            U_RESP:       w = '{C_OUT_FREE, U_IDLE, C_NEVER, U_IDLE, U_RESP,
                                A_RESP, ST_OK};
            default:      w = '{C_NEVER, U_IDLE, C_NEVER, U_IDLE, U_IDLE,
                                A_NONE, ST_OK};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/first_fit_block_allocator.sv
// Steps from input transfer to result valid: dispatch; zero size: error step; free: handle check, then
//   free or bad-handle step; allocate: scan, then claim, or append check, then append or out of space;
//   the response step then loads the output. One item at a time; the scan reads one entry per cycle
//   and the next item is taken the cycle after its result is loaded, even while it waits.
// Reset (aresetn low, synchronous): empties the table and arena, clears the output valid;
//   table memory contents are not cleared; entries not yet written may be read but are never used.
module first_fit_block_allocator
    import ffba_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // request_bytes[11:0], block_handle[17:12], zeros
    input  logic                s_tuser,   // func
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // payload_offset[10:0], granted_index[16:11],
                                           // granted_size[28:17], zeros
    output logic [STAT_W-1:0]   m_tuser    // status
);

    localparam logic [OFF_W-1:0] HDR_OFF = OFF_W'(HEADER_BYTES);

    // Table memory
    entry_t entry_mem [MAX_BLOCKS];

    // Sequencer and datapath registers
    step_t             upc_reg, upc_next;
    logic              func_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [IDX_W-1:0]  handle_reg;
    logic [CNT_W-1:0]  entry_count_reg;
    logic [TOP_W-1:0]  arena_top_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic              pend_vld_reg;
    logic [IDX_W-1:0]  pend_idx_reg;
    entry_t            rd_entry_reg;
    status_t           res_status_reg;
    logic [OFF_W-1:0]  res_off_reg;
    logic [IDX_W-1:0]  res_idx_reg;
    logic [SIZE_W-1:0] res_size_reg;
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [STAT_W-1:0] m_tuser_reg;

    // Decoded control
    cw_t               cw;
    logic              in_xfer;
    logic              hit;
    logic              scan_end;
    logic              full;
    logic              bad_handle;
    logic              out_free;
    logic              take_a;
    logic              take_b;
    logic [SUM_W-1:0]  top_sum;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    entry_t            mem_wdata;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_raddr;
    logic              scan_adv;

    assign cw = ucode(upc_reg);

    // Status flags for the jump conditions
    assign in_xfer    = s_tvalid && s_tready;
    assign hit        = pend_vld_reg && rd_entry_reg.free && (rd_entry_reg.size >= req_reg);
    assign scan_end   = !pend_vld_reg;
    assign top_sum    = SUM_W'(arena_top_reg) + SUM_W'(HEADER_BYTES) + SUM_W'(req_reg);
    assign full       = (entry_count_reg >= CNT_W'(MAX_BLOCKS))
                        || (top_sum > SUM_W'(ARENA_BYTES));
    assign bad_handle = ({1'b0, handle_reg} >= entry_count_reg);
    assign out_free   = !m_tvalid_reg || m_tready;

    // Evaluate both jump conditions of the current control word
    always_comb begin
        unique case (cw.cond_a)
            C_IN_XFER:    take_a = in_xfer;
            C_FUNC_FREE:  take_a = (func_reg == FN_FREE);
            C_REQ_ZERO:   take_a = (req_reg == '0);
            C_HIT:        take_a = hit;
            C_SCAN_END:   take_a = scan_end;
            C_FULL:       take_a = full;
            C_BAD_HANDLE: take_a = bad_handle;
            C_OUT_FREE:   take_a = out_free;
            default:      take_a = 1'b0;
        endcase
        unique case (cw.cond_b)
            C_IN_XFER:    take_b = in_xfer;
            C_FUNC_FREE:  take_b = (func_reg == FN_FREE);
            C_REQ_ZERO:   take_b = (req_reg == '0);
            C_HIT:        take_b = hit;
            C_SCAN_END:   take_b = scan_end;
            C_FULL:       take_b = full;
            C_BAD_HANDLE: take_b = bad_handle;
            C_OUT_FREE:   take_b = out_free;
            default:      take_b = 1'b0;
        endcase
    end

    // Next step
    always_comb begin
        priority if (take_a) begin
            upc_next = cw.tgt_a;
        end else if (take_b) begin
            upc_next = cw.tgt_b;
        end else begin
            upc_next = cw.tgt_else;
        end
    end

    // Memory port controls from the current operation
    always_comb begin
        s_tready  = (cw.act == A_ACCEPT);
        scan_adv  = (cw.act == A_SCAN) && !hit && !scan_end;
        mem_re    = 1'b0;
        mem_raddr = scan_idx_reg[IDX_W-1:0];
        mem_we    = 1'b0;
        mem_waddr = pend_idx_reg;
        mem_wdata = rd_entry_reg;
        unique case (cw.act)
            A_ACCEPT: begin
                mem_re    = in_xfer;
                mem_raddr = s_tuser ? s_tdata[SIZE_W +: IDX_W] : '0;
            end
            A_SCAN: begin
                mem_re = scan_adv;
            end
            A_CLAIM: begin
                mem_we         = 1'b1;
                mem_wdata.free = 1'b0;
            end
            A_APPEND: begin
                mem_we    = 1'b1;
                mem_waddr = entry_count_reg[IDX_W-1:0];
                mem_wdata = '{size: req_reg, start: arena_top_reg[OFF_W-1:0], free: 1'b0};
            end
            A_FREE: begin
                mem_we         = 1'b1;
                mem_waddr      = handle_reg;
                mem_wdata.free = 1'b1;
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_entry_reg <= entry_mem[mem_raddr];
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg         <= U_IDLE;
            entry_count_reg <= '0;
            arena_top_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
            pend_vld_reg    <= 1'b0;
        end else begin
            upc_reg <= upc_next;
            // prime the scan with entry 0 on accept, advance one entry per scan step
            if (cw.act == A_ACCEPT && in_xfer) begin
                pend_vld_reg <= (entry_count_reg != '0);
            end else if (scan_adv) begin
                pend_vld_reg <= (scan_idx_reg < entry_count_reg);
            end
            // append the new block at the arena top
            if (cw.act == A_APPEND) begin
                entry_count_reg <= entry_count_reg + 1'b1;
                arena_top_reg   <= top_sum[TOP_W-1:0];
            end
            // load the output register, drop it once taken
            if (cw.act == A_RESP && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cw.act == A_ACCEPT && in_xfer) begin
            func_reg     <= s_tuser;
            req_reg      <= s_tdata[SIZE_W-1:0];
            handle_reg   <= s_tdata[SIZE_W +: IDX_W];
            pend_idx_reg <= '0;
            scan_idx_reg <= CNT_W'(1);
        end else if (scan_adv) begin
            pend_idx_reg <= scan_idx_reg[IDX_W-1:0];
            scan_idx_reg <= scan_idx_reg + 1'b1;
        end
        unique case (cw.act)
            A_CLAIM: begin
                res_status_reg <= ST_OK;
                res_off_reg    <= rd_entry_reg.start + HDR_OFF;
                res_idx_reg    <= pend_idx_reg;
                res_size_reg   <= rd_entry_reg.size;
            end
            A_APPEND: begin
                res_status_reg <= ST_OK;
                res_off_reg    <= arena_top_reg[OFF_W-1:0] + HDR_OFF;
                res_idx_reg    <= entry_count_reg[IDX_W-1:0];
                res_size_reg   <= req_reg;
            end
            A_FREE: begin
                res_status_reg <= ST_OK;
                res_off_reg    <= rd_entry_reg.start + HDR_OFF;
                res_idx_reg    <= handle_reg;
                res_size_reg   <= rd_entry_reg.size;
            end
            A_ERR: begin
                res_status_reg <= cw.st;
                res_off_reg    <= '0;
                res_idx_reg    <= '0;
                res_size_reg   <= '0;
            end
            default: begin
                res_status_reg <= res_status_reg;
            end
        endcase
        if (cw.act == A_RESP && out_free) begin
            m_tdata_reg <= M_DATA_W'({res_size_reg, res_idx_reg, res_off_reg});
            m_tuser_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: rtl/core/ffba_checker.sv
// Port-level checker for the first-fit block allocator, with its bind.
module ffba_checker
    import ffba_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [S_DATA_W-1:0] s_tdata,
    input logic                s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]   m_tuser
);

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Rejected requests carry all-zero result fields
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata == '0))
        else $error("error result with nonzero fields");

    // A granted block has a nonzero size and its payload sits after the header
    a_ok_sane: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == ST_OK) |->
            (m_tdata[OFF_W+IDX_W +: SIZE_W] != '0)
            && (m_tdata[OFF_W-1:0] >= OFF_W'(HEADER_BYTES)))
        else $error("granted block with bad size or offset");

    // One item in flight: s_tready drops after each input transfer
    a_no_accept_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);
